// File: hw/rtl/smbe_pkg.sv
// Shared types and constants of the SPI master byte exchanger.
`timescale 1ns / 1ps

package smbe_pkg;

  localparam int unsigned BITS_PER_WORD = 8;
  localparam int unsigned CFG_DATA_W    = 16;

  // Configuration register indexes
  localparam logic REG_SPI_MODE          = 1'b0;
  localparam logic REG_QUARTER_BIT_TICKS = 1'b1;

  localparam logic [15:0] QUARTER_BIT_TICKS_RESET = 16'd10;

  typedef struct packed {
    logic                     func;
    logic [BITS_PER_WORD-1:0] tx_byte;
    logic                     last_byte;
    logic                     miso_level;
  } in_item_t;

  typedef struct packed {
    logic                     sclk_level;
    logic                     mosi_level;
    logic                     select_n;
    logic                     byte_taken;
    logic                     rx_valid;
    logic [BITS_PER_WORD-1:0] rx_byte;
    logic                     busy_res;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic                  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: hw/rtl/spi_master_byte_exchanger.sv
// Top level of the SPI master byte exchanger.
`timescale 1ns / 1ps

// SPI master stepped by one input item per tick. Each item carries the MISO
// level and may offer a byte (func high); each item yields exactly one result
// with the SCLK/MOSI/select pin levels after that tick, byte_taken, rx_valid
// with the received byte, and busy_res.
// Input channel: a transfer happens when push is high and full is low.
// Result channel: the oldest result sits on the result ports while empty is
// low; a transfer happens when pop is high and empty is low.
// Path: input queue (IN_DEPTH) -> sequencer -> result queue (OUT_DEPTH).
// The sequencer advances one tick per cycle whenever the input queue holds an
// item and the result queue has room; one item per cycle is sustained while the
// result side pops every cycle. Each item is registered in the input queue, and
// its result is registered in the result queue before it reaches the ports.
// When the result side stalls, the result queue fills, the sequencer holds,
// then the input queue fills and full rises; nothing is dropped.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) must only be used while
// both queues are empty.
// Reset: queues empty, mode 0, quarter_bit_ticks 10, SCLK low, MOSI and select
// high, no frame open.
module spi_master_byte_exchanger #(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        last_byte_i,
  input  logic        miso_level_i,
  // results
  input  logic        pop,
  output logic        empty,
  output logic        sclk_level_o,
  output logic        mosi_level_o,
  output logic        select_n_o,
  output logic        byte_taken_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_byte_o,
  output logic        busy_res_o
);

  localparam int unsigned IN_W  = $bits(smbe_pkg::in_item_t);
  localparam int unsigned OUT_W = $bits(smbe_pkg::result_t);

  smbe_pkg::in_item_t in_item, q_item;
  smbe_pkg::result_t  eng_res, out_res;
  smbe_pkg::cfg_wr_t  cfg;
  logic               in_empty;
  logic               out_full;
  logic               step;

  assign in_item.func       = func_i;
  assign in_item.tx_byte    = tx_byte_i;
  assign in_item.last_byte  = last_byte_i;
  assign in_item.miso_level = miso_level_i;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // one tick per cycle while an item waits and a result slot is free
  assign step = !in_empty && !out_full;

  smbe_fifo #(
    .WIDTH (IN_W),
    .DEPTH (IN_DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item),
    .full_o  (full),
    .pop_i   (step),
    .data_o  (q_item),
    .empty_o (in_empty)
  );

  smbe_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (q_item),
    .res_o  (eng_res)
  );

  smbe_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (eng_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign sclk_level_o = out_res.sclk_level;
  assign mosi_level_o = out_res.mosi_level;
  assign select_n_o   = out_res.select_n;
  assign byte_taken_o = out_res.byte_taken;
  assign rx_valid_o   = out_res.rx_valid;
  assign rx_byte_o    = out_res.rx_byte;
  assign busy_res_o   = out_res.busy_res;

endmodule

// File: hw/rtl/smbe_fifo.sv
// Small synchronous queue; DEPTH is a power of two, at least 2.
`timescale 1ns / 1ps

module smbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/smbe_engine.sv
// SPI sequencer: phase machine, delay counter, shift registers and pin levels.
`timescale 1ns / 1ps

module smbe_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smbe_pkg::cfg_wr_t  cfg_i,
  input  logic             step_i,
  input  smbe_pkg::in_item_t item_i,
  output smbe_pkg::result_t  res_o
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_EDGE_IN  = 4'd3;
  localparam logic [3:0] PH_SET_MOSI = 4'd4;
  localparam logic [3:0] PH_EDGE_EFF = 4'd5;
  localparam logic [3:0] PH_SAMPLE   = 4'd6;
  localparam logic [3:0] PH_STOP_A   = 4'd7;
  localparam logic [3:0] PH_STOP_B   = 4'd8;
  localparam logic [3:0] PH_STOP_C   = 4'd9;
  localparam logic [3:0] PH_STOP_D   = 4'd10;

  localparam int unsigned BW = smbe_pkg::BITS_PER_WORD;
  localparam int unsigned IW = $clog2(BW);
  localparam logic [IW-1:0] LAST_BIT = IW'(BW - 1);

  logic [1:0]    mode_q, mode_d;
  logic [15:0]   qbt_q, qbt_d;
  logic [3:0]    phase_q, phase_d, ph_cur;
  logic [15:0]   tick_q, tick_d;
  logic [IW-1:0] bit_q, bit_d;
  logic [BW-1:0] tx_q, tx_d;
  logic [BW-1:0] rx_q, rx_d;
  logic          ending_q, ending_d;
  logic          in_frame_q, in_frame_d;
  logic          sclk_q, sclk_d;
  logic          mosi_q, mosi_d;
  logic          sel_q, sel_d;
  logic          rxv;
  logic          taken;
  logic          eff_level;

  // unused codes fall back to idle
  assign ph_cur    = (phase_q > PH_STOP_D) ? PH_IDLE : phase_q;
  // effective edge drives high in modes 0 and 3
  assign eff_level = ~(mode_q[1] ^ mode_q[0]);

  always_comb begin
    mode_d     = mode_q;
    qbt_d      = qbt_q;
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    tx_d       = tx_q;
    rx_d       = rx_q;
    ending_d   = ending_q;
    in_frame_d = in_frame_q;
    sclk_d     = sclk_q;
    mosi_d     = mosi_q;
    sel_d      = sel_q;
    rxv        = 1'b0;
    taken      = 1'b0;

    if (step_i) begin
      phase_d = ph_cur;
      if (ph_cur == PH_IDLE) begin
        if (item_i.func) begin
          taken    = 1'b1;
          tx_d     = item_i.tx_byte;
          rx_d     = '0;
          bit_d    = '0;
          ending_d = item_i.last_byte;
          phase_d  = in_frame_q ? PH_EDGE_IN : PH_START_A;
          tick_d   = '0;
        end
      end else if (tick_q < qbt_q) begin
        tick_d = tick_q + 16'd1;
      end else begin
        tick_d = '0;
        unique case (ph_cur)
          PH_START_A: begin
            sel_d      = 1'b0;
            in_frame_d = 1'b1;
            phase_d    = PH_START_B;
          end
          PH_START_B: begin
            phase_d = PH_EDGE_IN;
          end
          PH_EDGE_IN: begin
            sclk_d  = ~eff_level;
            phase_d = PH_SET_MOSI;
          end
          PH_SET_MOSI: begin
            mosi_d  = tx_q[BW-1];
            tx_d    = {tx_q[BW-2:0], 1'b0};
            phase_d = PH_EDGE_EFF;
          end
          PH_EDGE_EFF: begin
            sclk_d  = eff_level;
            phase_d = PH_SAMPLE;
          end
          PH_SAMPLE: begin
            rx_d = {rx_q[BW-2:0], item_i.miso_level};
            if (bit_q == LAST_BIT) begin
              bit_d   = '0;
              rxv     = 1'b1;
              phase_d = ending_q ? PH_STOP_A : PH_IDLE;
            end else begin
              bit_d   = bit_q + 1'b1;
              phase_d = PH_EDGE_IN;
            end
          end
          PH_STOP_A: begin
            sclk_d  = mode_q[1];
            phase_d = PH_STOP_B;
          end
          PH_STOP_B: begin
            mosi_d  = 1'b1;
            phase_d = PH_STOP_C;
          end
          PH_STOP_C: begin
            sel_d   = 1'b1;
            phase_d = PH_STOP_D;
          end
          default: begin
            in_frame_d = 1'b0;
            ending_d   = 1'b0;
            phase_d    = PH_IDLE;
          end
        endcase
      end
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        smbe_pkg::REG_SPI_MODE: begin
          mode_d = cfg_i.data[1:0];
          // outside a frame SCLK follows the new idle level at once
          if (ph_cur == PH_IDLE && !in_frame_q) begin
            sclk_d = cfg_i.data[1];
          end
        end
        smbe_pkg::REG_QUARTER_BIT_TICKS: begin
          qbt_d = cfg_i.data[15:0];
        end
        default: begin
          qbt_d = qbt_q;
        end
      endcase
    end
  end

  always_comb begin
    res_o.sclk_level = sclk_d;
    res_o.mosi_level = mosi_d;
    res_o.select_n   = sel_d;
    res_o.byte_taken = taken;
    res_o.rx_valid   = rxv;
    res_o.rx_byte    = rxv ? rx_d : '0;
    res_o.busy_res   = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 2'd0;
      qbt_q      <= smbe_pkg::QUARTER_BIT_TICKS_RESET;
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      tx_q       <= '0;
      rx_q       <= '0;
      ending_q   <= 1'b0;
      in_frame_q <= 1'b0;
      sclk_q     <= 1'b0;
      mosi_q     <= 1'b1;
      sel_q      <= 1'b1;
    end else begin
      mode_q     <= mode_d;
      qbt_q      <= qbt_d;
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      tx_q       <= tx_d;
      rx_q       <= rx_d;
      ending_q   <= ending_d;
      in_frame_q <= in_frame_d;
      sclk_q     <= sclk_d;
      mosi_q     <= mosi_d;
      sel_q      <= sel_d;
    end
  end

endmodule

// File: tb/smbe_result_checker.sv
// Result checker for the SPI master byte exchanger: tick predictor and scoreboard.
`timescale 1ns / 1ps

module smbe_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        func_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        last_byte_i,
  input  logic        miso_level_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic        sclk_level_i,
  input  logic        mosi_level_i,
  input  logic        select_n_i,
  input  logic        byte_taken_i,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        busy_res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_A,
    SEQ_START_B,
    SEQ_EDGE_IN,
    SEQ_SET_MOSI,
    SEQ_EDGE_EFF,
    SEQ_SAMPLE,
    SEQ_STOP_A,
    SEQ_STOP_B,
    SEQ_STOP_C,
    SEQ_STOP_D
  } seq_phase_e;

  // predicted block state
  logic [1:0]  spi_mode;
  logic [15:0] quarter_ticks;
  seq_phase_e  seq_phase;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  tx_sr;
  logic [7:0]  rx_sr;
  logic        closing;
  logic        frame_open;
  logic        sclk;
  logic        mosi;
  logic        sel_n;

  smbe_pkg::result_t expected_pins_q[$];

  function automatic void enter(seq_phase_e nxt);
    seq_phase = nxt;
    tick_cnt  = '0;
  endfunction

  // effective edge level: high in modes 0 and 3
  function automatic logic eff_level();
    return ~(spi_mode[1] ^ spi_mode[0]);
  endfunction

  function automatic smbe_pkg::result_t step_spi_tick(smbe_pkg::in_item_t it);
    smbe_pkg::result_t r;
    r = '0;
    if (seq_phase == SEQ_IDLE) begin
      if (it.func) begin
        r.byte_taken = 1'b1;
        tx_sr        = it.tx_byte;
        rx_sr        = '0;
        bit_idx      = '0;
        closing      = it.last_byte;
        enter(frame_open ? SEQ_EDGE_IN : SEQ_START_A);
      end
    end else if (tick_cnt < quarter_ticks) begin
      tick_cnt = tick_cnt + 16'd1;
    end else begin
      case (seq_phase)
        SEQ_START_A: begin
          sel_n      = 1'b0;
          frame_open = 1'b1;
          enter(SEQ_START_B);
        end
        SEQ_START_B: enter(SEQ_EDGE_IN);
        SEQ_EDGE_IN: begin
          sclk = ~eff_level();
          enter(SEQ_SET_MOSI);
        end
        SEQ_SET_MOSI: begin
          mosi  = tx_sr[7];
          tx_sr = {tx_sr[6:0], 1'b0};
          enter(SEQ_EDGE_EFF);
        end
        SEQ_EDGE_EFF: begin
          sclk = eff_level();
          enter(SEQ_SAMPLE);
        end
        SEQ_SAMPLE: begin
          rx_sr = {rx_sr[6:0], it.miso_level};
          if (bit_idx == 3'(smbe_pkg::BITS_PER_WORD - 1)) begin
            bit_idx    = '0;
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_sr;
            enter(closing ? SEQ_STOP_A : SEQ_IDLE);
          end else begin
            bit_idx = bit_idx + 3'd1;
            enter(SEQ_EDGE_IN);
          end
        end
        SEQ_STOP_A: begin
          sclk = spi_mode[1];
          enter(SEQ_STOP_B);
        end
        SEQ_STOP_B: begin
          mosi = 1'b1;
          enter(SEQ_STOP_C);
        end
        SEQ_STOP_C: begin
          sel_n = 1'b1;
          enter(SEQ_STOP_D);
        end
        default: begin
          frame_open = 1'b0;
          closing    = 1'b0;
          enter(SEQ_IDLE);
        end
      endcase
    end
    r.sclk_level = sclk;
    r.mosi_level = mosi;
    r.select_n   = sel_n;
    r.busy_res   = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    fail_count_o = fail_count_o + 1;
    $display("[%0t] mismatch: %s got %0h, expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    smbe_pkg::in_item_t it;
    smbe_pkg::result_t  got;
    smbe_pkg::result_t  want;
    if (!rst_ni) begin
      spi_mode      = 2'd0;
      quarter_ticks = smbe_pkg::QUARTER_BIT_TICKS_RESET;
      seq_phase     = SEQ_IDLE;
      tick_cnt      = '0;
      bit_idx       = '0;
      tx_sr         = '0;
      rx_sr         = '0;
      closing       = 1'b0;
      frame_open    = 1'b0;
      sclk          = 1'b0;
      mosi          = 1'b1;
      sel_n         = 1'b1;
      expected_pins_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == smbe_pkg::REG_SPI_MODE) begin
          spi_mode = cfg_data_i[1:0];
          // outside a frame the clock follows the new idle level at once
          if (seq_phase == SEQ_IDLE && !frame_open) sclk = spi_mode[1];
        end else begin
          quarter_ticks = cfg_data_i;
        end
      end
      if (pop_i && !empty_i) begin
        got = {sclk_level_i, mosi_level_i, select_n_i, byte_taken_i,
               rx_valid_i, rx_byte_i, busy_res_i};
        if (expected_pins_q.size() == 0) begin
          report_mismatch("unexpected result transfer", got, 0);
        end else begin
          want = expected_pins_q.pop_front();
          if (got.sclk_level !== want.sclk_level)
            report_mismatch("sclk_level", got.sclk_level, want.sclk_level);
          if (got.mosi_level !== want.mosi_level)
            report_mismatch("mosi_level", got.mosi_level, want.mosi_level);
          if (got.select_n !== want.select_n)
            report_mismatch("select_n", got.select_n, want.select_n);
          if (got.byte_taken !== want.byte_taken)
            report_mismatch("byte_taken", got.byte_taken, want.byte_taken);
          if (got.rx_valid !== want.rx_valid)
            report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
          if (got.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        end
      end
      if (push_i && !full_i) begin
        it = {func_i, tx_byte_i, last_byte_i, miso_level_i};
        expected_pins_q.push_back(step_spi_tick(it));
      end
    end
    pending_o = expected_pins_q.size();
  end

endmodule

// File: tb/tb_spi_master_byte_exchanger.sv
// Testbench top for the SPI master byte exchanger: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_spi_master_byte_exchanger;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic        cfg_idx_i    = 1'b0;
  logic [15:0] cfg_data_i   = '0;
  logic        push         = 1'b0;
  logic        full;
  logic        func_i       = 1'b0;
  logic [7:0]  tx_byte_i    = '0;
  logic        last_byte_i  = 1'b0;
  logic        miso_level_i = 1'b0;
  logic        pop          = 1'b0;
  logic        empty;
  logic        sclk_level_o;
  logic        mosi_level_o;
  logic        select_n_o;
  logic        byte_taken_o;
  logic        rx_valid_o;
  logic [7:0]  rx_byte_o;
  logic        busy_res_o;

  int unsigned fail_count;
  int unsigned pending;

  // pacing: percent of cycles the sender sits idle / the receiver stalls
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  // 2 ns clock period
  always #1 clk_i = ~clk_i;

  spi_master_byte_exchanger i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .tx_byte_i   (tx_byte_i),
    .last_byte_i (last_byte_i),
    .miso_level_i(miso_level_i),
    .pop         (pop),
    .empty       (empty),
    .sclk_level_o(sclk_level_o),
    .mosi_level_o(mosi_level_o),
    .select_n_o  (select_n_o),
    .byte_taken_o(byte_taken_o),
    .rx_valid_o  (rx_valid_o),
    .rx_byte_o   (rx_byte_o),
    .busy_res_o  (busy_res_o)
  );

  // Watches both channels and the register port; predicts and compares.
  smbe_result_checker i_result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_i      (full),
    .func_i      (func_i),
    .tx_byte_i   (tx_byte_i),
    .last_byte_i (last_byte_i),
    .miso_level_i(miso_level_i),
    .pop_i       (pop),
    .empty_i     (empty),
    .sclk_level_i(sclk_level_o),
    .mosi_level_i(mosi_level_o),
    .select_n_i  (select_n_o),
    .byte_taken_i(byte_taken_o),
    .rx_valid_i  (rx_valid_o),
    .rx_byte_i   (rx_byte_o),
    .busy_res_i  (busy_res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Result side: pop is redrawn every falling edge. With a zero stall rate
  // it stays high, so back-to-back transfers are exercised too.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // One input transfer. Optional idle cycles come first (push low), then the
  // item is held until the rising edge where full is low. push is assigned
  // once per falling edge, so a held-high push is never toggled in one step.
  task automatic offer_tick(logic f, logic [7:0] b, logic l, logic m);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    push         <= 1'b1;
    func_i       <= f;
    tx_byte_i    <= b;
    last_byte_i  <= l;
    miso_level_i <= m;
    do @(posedge clk_i); while (full);
  endtask

  // Stop sending and wait until every expected result has been transferred.
  // Each tick yields exactly one result, so once none is pending both queues
  // are empty; the trailing wait only spaces out the next register write.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes, only issued while both queues are drained. Upper bits
  // of the mode write are random to check that only two bits are used.
  task automatic program_regs(logic [1:0] mode, logic [15:0] qbt);
    logic [15:0] mode_word;
    mode_word      = 16'($urandom_range(0, 65535));
    mode_word[1:0] = mode;
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= smbe_pkg::REG_SPI_MODE;
    cfg_data_i <= mode_word;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_idx_i  <= smbe_pkg::REG_QUARTER_BIT_TICKS;
    cfg_data_i <= qbt;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] qbt;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: mode 2 outside a frame moves SCLK high at once; zero delay
    // makes each step act on its first tick. An all-ones last byte starts a
    // frame, MISO toggles while bits shift, and an offer while busy must be
    // ignored.
    program_regs(2'd2, 16'd0);
    offer_tick(1'b1, 8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 20; i++) offer_tick(1'b0, 8'h00, 1'b0, 1'(i));
    offer_tick(1'b1, 8'h00, 1'b0, 1'b1);
    settle();
    // mode change mid-byte, then the longest delay: the current step stalls
    program_regs(2'd1, 16'hFFFF);
    repeat (3) offer_tick(1'b0, 8'h00, 1'b0, 1'b1);
    settle();
    // delay lowered mid-step: the stalled step acts right away
    program_regs(2'd1, 16'd0);

    // Random phases. Most phases use short delays; one phase runs the longest delay
    // and the next one lowers it mid-step. Offers come in about a third of the
    // ticks, a third of them close the frame.
    for (int p = 0; p < 12; p++) begin
      case (p)
        5:       qbt = 16'hFFFF;
        8:       qbt = 16'd5;
        default: qbt = 16'(p % 4);
      endcase
      case ((p / 2) % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      program_regs(2'((p / 3) % 4), qbt);
      repeat ((qbt == 16'hFFFF) ? 40 : 160) begin
        offer_tick($urandom_range(0, 99) < 35, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run (about 2000 ticks, each
  // with sender gaps and receiver stalls).
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/smbe_pkg.sv
hw/rtl/smbe_fifo.sv
hw/rtl/smbe_engine.sv
hw/rtl/spi_master_byte_exchanger.sv
tb/smbe_result_checker.sv
tb/tb_spi_master_byte_exchanger.sv
